// ----- rtl/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, register codes, command/status types and helper functions
// of the pixel replication scaler.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int DimW      = 13;	// dimension registers, holds 1..MaxDim
	localparam int CoordW    = 12;	// destination / source coordinates
	localparam int PixW      = 32;	// pixel word
	localparam int MaxDim    = 4096;
	localparam int MaxRepeat = 8;
	localparam int RptW      = $clog2(MaxRepeat + 1);	// repeat count 1..MaxRepeat
	localparam int OffW      = (MaxRepeat > 1) ? $clog2(MaxRepeat) : 1;	// offset in block
	localparam int CfgIdxW   = 2;
	localparam int DivSteps  = DimW;
	localparam int DivCntW   = $clog2(DivSteps + 1);

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} psc_reg_t;

	// controller to datapath
	typedef struct packed {
		logic div_start;	// recompute the scale ratios
		logic load;	// take a source word, set up its block
		logic step;	// current write taken, move to the next one
	} psc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;	// ratios valid this cycle
		logic last;	// current write ends the block
	} psc_sts_t;

	// out-of-range dimensions: 0 reads as 1, above MaxDim reads as MaxDim
	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
		logic [DimW-1:0] r;
		r = v;
		if (v == '0)
			r = DimW'(1);
		else if (v > DimW'(MaxDim))
			r = DimW'(MaxDim);
		return r;
	endfunction

	// ceil(dst/src) from quotient and remainder, saturated at MaxRepeat
	function automatic logic [RptW-1:0] repeat_of(input logic [DimW-1:0] quo,
			input logic [DimW-1:0] rem);
		logic [RptW-1:0] r;
		if (quo >= DimW'(MaxRepeat))
			r = RptW'(MaxRepeat);
		else
			r = RptW'(quo) + RptW'(rem != '0);
		return r;
	endfunction

endpackage

// ----- rtl/psc_if.sv -----
// ----------------------------------------------------------------------------
// psc_pix_if / psc_wr_if
// Valid/ready channels: source pixel words in, destination write words out.
// ----------------------------------------------------------------------------
interface psc_pix_if import psc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PixW-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface psc_wr_if import psc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CoordW-1:0] dest_col;
	logic [CoordW-1:0] dest_row;
	logic [PixW-1:0]   pixel_out;
	logic              last_of_run;
	logic              last_of_frame;

	modport source (output valid, output dest_col, output dest_row, output pixel_out,
		output last_of_run, output last_of_frame, input ready);
	modport sink (input valid, input dest_col, input dest_row, input pixel_out,
		input last_of_run, input last_of_frame, output ready);
endinterface

// ----- rtl/psc_div.sv -----
// ----------------------------------------------------------------------------
// psc_div
// Restoring divider, one quotient bit per cycle, DivSteps steps per result.
// ----------------------------------------------------------------------------
module psc_div import psc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DimW-1:0] dividend,
	input  logic [DimW-1:0] divisor,
	output logic [DimW-1:0] quotient,
	output logic [DimW-1:0] remainder,
	output logic            done
);

	logic [DivCntW-1:0] cnt_q;
	logic               done_q;
	logic [DimW-1:0]    acc_q;
	logic [DimW-1:0]    quo_q;
	logic [DimW-1:0]    dvs_q;
	logic [DimW:0]      shifted;
	logic [DimW:0]      trial;

	// shift in the next dividend bit and try the subtract
	assign shifted = {acc_q, quo_q[DimW-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DivCntW'(DivSteps);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DivCntW'(1);
				if (cnt_q == DivCntW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[DimW]) begin
				acc_q <= trial[DimW-1:0];
				quo_q <= {quo_q[DimW-2:0], 1'b1};
			end else begin
				acc_q <= shifted[DimW-1:0];
				quo_q <= {quo_q[DimW-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = acc_q;
	assign done      = done_q;

endmodule

// ----- rtl/psc_dpath.sv -----
// ----------------------------------------------------------------------------
// psc_dpath
// Scaler datapath: dimension registers, ratio dividers, incremental block
// origin tracking and the destination write generator with output register.
// ----------------------------------------------------------------------------
module psc_dpath import psc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DimW-1:0]    cfg_wdata,
	input  psc_cmd_t           cmd,
	output psc_sts_t           sts,
	input  logic [PixW-1:0]    pixel_in,
	output logic [CoordW-1:0]  dest_col,
	output logic [CoordW-1:0]  dest_row,
	output logic [PixW-1:0]    pixel_out,
	output logic               last_of_run,
	output logic               last_of_frame
);

	// configuration, stored already clamped
	logic [DimW-1:0] sw_q, sh_q, dw_q, dh_q;
	// ratios dst/src: quotient, remainder, repeat count
	logic [DimW-1:0] qx_q, rx_q, qy_q, ry_q;
	logic [RptW-1:0] rptx_q, rpty_q;
	// source position and block origin with fractional part
	logic [CoordW-1:0] col_q, row_q, bx_q, by_q;
	logic [DimW-1:0]   fx_q, fy_q;
	// write generator
	logic [CoordW-1:0] bcol_q, ecol_q, erow_q;
	logic [OffW-1:0]   ox_q, oy_q, ncm1_q, nrm1_q;
	logic [PixW-1:0]   pix_q;
	logic              last_q, fend_q;

	logic [DimW-1:0] dqx, drx, dqy, dry;
	logic            donex, doney;

	psc_div u_divx (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dw_q),
		.divisor  (sw_q),
		.quotient (dqx),
		.remainder(drx),
		.done     (donex)
	);

	psc_div u_divy (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dh_q),
		.divisor  (sh_q),
		.quotient (dqy),
		.remainder(dry),
		.done     (doney)
	);

	assign sts.div_done = donex & doney;
	assign sts.last     = last_q;

	// block size clipped at the destination edge
	logic [DimW-1:0] room_c, room_r;
	logic [RptW-1:0] ncols, nrows;
	logic            frame_end, col_wrap, row_wrap;

	assign room_c    = dw_q - DimW'(bx_q);
	assign room_r    = dh_q - DimW'(by_q);
	assign ncols     = (room_c < DimW'(rptx_q)) ? RptW'(room_c) : rptx_q;
	assign nrows     = (room_r < DimW'(rpty_q)) ? RptW'(room_r) : rpty_q;
	assign col_wrap  = (DimW'(col_q) + DimW'(1)) >= sw_q;
	assign row_wrap  = (DimW'(row_q) + DimW'(1)) >= sh_q;
	assign frame_end = col_wrap & row_wrap;

	// next block origin: add the ratio, carry the fraction once
	logic [DimW:0]   fxs, fys;
	logic            cx, cy;
	logic [DimW-1:0] fx_n, fy_n;
	logic [DimW:0]   bx_n, by_n;

	assign fxs  = {1'b0, fx_q} + {1'b0, rx_q};
	assign fys  = {1'b0, fy_q} + {1'b0, ry_q};
	assign cx   = fxs >= {1'b0, sw_q};
	assign cy   = fys >= {1'b0, sh_q};
	assign fx_n = cx ? DimW'(fxs - {1'b0, sw_q}) : fxs[DimW-1:0];
	assign fy_n = cy ? DimW'(fys - {1'b0, sh_q}) : fys[DimW-1:0];
	assign bx_n = (DimW+1)'(bx_q) + (DimW+1)'(qx_q) + (DimW+1)'(cx);
	assign by_n = (DimW+1)'(by_q) + (DimW+1)'(qy_q) + (DimW+1)'(cy);

	// next write inside the block
	logic            end_col;
	logic [OffW-1:0] ox_n, oy_n;

	assign end_col = ox_q == ncm1_q;
	assign ox_n    = end_col ? '0 : ox_q + OffW'(1);
	assign oy_n    = end_col ? oy_q + OffW'(1) : oy_q;

	// control state: configuration, ratios, position, write counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= DimW'(1);
			sh_q   <= DimW'(1);
			dw_q   <= DimW'(1);
			dh_q   <= DimW'(1);
			qx_q   <= DimW'(1);
			rx_q   <= '0;
			qy_q   <= DimW'(1);
			ry_q   <= '0;
			rptx_q <= RptW'(1);
			rpty_q <= RptW'(1);
			col_q  <= '0;
			row_q  <= '0;
			bx_q   <= '0;
			by_q   <= '0;
			fx_q   <= '0;
			fy_q   <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
			ncm1_q <= '0;
			nrm1_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (psc_reg_t'(cfg_index))
					REG_SRC_WIDTH:  sw_q <= clamp_dim(cfg_wdata);
					REG_SRC_HEIGHT: sh_q <= clamp_dim(cfg_wdata);
					REG_DST_WIDTH:  dw_q <= clamp_dim(cfg_wdata);
					REG_DST_HEIGHT: dh_q <= clamp_dim(cfg_wdata);
					default: ;
				endcase
				// any write starts a new frame
				col_q <= '0;
				row_q <= '0;
				bx_q  <= '0;
				by_q  <= '0;
				fx_q  <= '0;
				fy_q  <= '0;
			end else if (cmd.load) begin
				// move the source position one pixel on
				if (col_wrap) begin
					col_q <= '0;
					bx_q  <= '0;
					fx_q  <= '0;
					if (row_wrap) begin
						row_q <= '0;
						by_q  <= '0;
						fy_q  <= '0;
					end else begin
						row_q <= row_q + CoordW'(1);
						by_q  <= CoordW'(by_n);
						fy_q  <= fy_n;
					end
				end else begin
					col_q <= col_q + CoordW'(1);
					bx_q  <= CoordW'(bx_n);
					fx_q  <= fx_n;
				end
			end

			if (sts.div_done) begin
				qx_q   <= dqx;
				rx_q   <= drx;
				qy_q   <= dqy;
				ry_q   <= dry;
				rptx_q <= repeat_of(dqx, drx);
				rpty_q <= repeat_of(dqy, dry);
			end

			if (cmd.load) begin
				ox_q   <= '0;
				oy_q   <= '0;
				ncm1_q <= OffW'(ncols - RptW'(1));
				nrm1_q <= OffW'(nrows - RptW'(1));
				last_q <= (ncols == RptW'(1)) && (nrows == RptW'(1));
			end else if (cmd.step) begin
				ox_q   <= ox_n;
				oy_q   <= oy_n;
				last_q <= (ox_n == ncm1_q) && (oy_n == nrm1_q);
			end
		end
	end

	// write payload register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q  <= pixel_in;
			fend_q <= frame_end;
			bcol_q <= bx_q;
			ecol_q <= bx_q;
			erow_q <= by_q;
		end else if (cmd.step) begin
			if (end_col) begin
				ecol_q <= bcol_q;
				erow_q <= erow_q + CoordW'(1);
			end else begin
				ecol_q <= ecol_q + CoordW'(1);
			end
		end
	end

	assign dest_col      = ecol_q;
	assign dest_row      = erow_q;
	assign pixel_out     = pix_q;
	assign last_of_run   = last_q;
	assign last_of_frame = fend_q;

endmodule

// ----- rtl/psc_ctrl.sv -----
// ----------------------------------------------------------------------------
// psc_ctrl
// Scaler controller: ratio recompute after configuration, word intake and
// write sequencing.
// ----------------------------------------------------------------------------
module psc_ctrl import psc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output psc_cmd_t cmd,
	input  psc_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   need_q;	// ratios stale after a configuration write
	logic   accept;
	logic   taken;

	assign in_ready  = (state_q == ST_IDLE) && !need_q;
	assign out_valid = state_q == ST_EMIT;
	assign accept    = in_valid && in_ready;
	assign taken     = out_valid && out_ready;

	assign cmd.div_start = (state_q == ST_IDLE) && need_q;
	assign cmd.load      = accept;
	assign cmd.step      = taken && !sts.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			need_q  <= 1'b0;
		end else begin
			if (cfg_we)
				need_q <= 1'b1;
			else if (cmd.div_start)
				need_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (need_q)
						state_q <= ST_DIV;
					else if (accept)
						state_q <= ST_EMIT;
				end
				ST_DIV: begin
					if (sts.div_done)
						state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (taken && sts.last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/pixel_replicate_scaler_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_replicate_scaler_unit
// Nearest-neighbor upscaler by pixel replication, top level.
// ----------------------------------------------------------------------------
// Usage:
//   src carries source pixel words in raster order; dst carries destination
//   write words (column, row, pixel, end-of-run and end-of-frame marks).
//   Each source word expands to a block of up to 8x8 writes, row by row,
//   clipped at the destination edge. The config port (cfg_we, cfg_index,
//   cfg_wdata) sets source and destination sizes; any write restarts the
//   frame at column 0, row 0. Write it only while the unit is idle.
// Timing:
//   After a config write the unit recomputes the size ratios in an iterative
//   divider with src.ready low until it is done. A source word is taken when
//   the unit is idle; its first write is presented the next cycle and one
//   write leaves per cycle while dst.ready is high. The block is sequenced
//   from one output register, so the next word waits until it is all taken.
// Reset and stall:
//   arst_n sets all sizes to 1 and the position to the frame origin; the
//   ratios need no recompute. A dst stall holds the current write and
//   src.ready stays low until the whole block has been taken.
// ----------------------------------------------------------------------------
module pixel_replicate_scaler_unit import psc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DimW-1:0]    cfg_wdata,
	psc_pix_if.sink            src,
	psc_wr_if.source           dst
);

	psc_cmd_t cmd;
	psc_sts_t sts;

	psc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (src.valid),
		.in_ready (src.ready),
		.out_valid(dst.valid),
		.out_ready(dst.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	psc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.pixel_in     (src.pixel_in),
		.dest_col     (dst.dest_col),
		.dest_row     (dst.dest_row),
		.pixel_out    (dst.pixel_out),
		.last_of_run  (dst.last_of_run),
		.last_of_frame(dst.last_of_frame)
	);

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for pixel_replicate_scaler_unit. Source pixel words are sent in
// raster order under a range of size settings; a predictor expands each
// accepted word into its block of destination writes. Every write taken from
// the unit is checked against the oldest pending write. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_top import psc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 2000;
	localparam int RandPhases    = 10;
	localparam int PhaseWords    = 24;

	// one destination write as seen on the output channel
	typedef struct packed {
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
		logic [PixW-1:0]   pix;
		logic              run_end;
		logic              frame_end;
	} wr_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [DimW-1:0]    cfg_wdata = '0;

	psc_pix_if pix ();
	psc_wr_if  wr ();

	pixel_replicate_scaler_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.src       (pix),
		.dst       (wr)
	);

	// predictor state: raw size registers and source position
	logic [DimW-1:0] size_reg [4] = '{default: DimW'(1)};
	int unsigned     cur_col = 0;
	int unsigned     cur_row = 0;

	wr_word_t pending_writes [$];
	int       fail_count = 0;
	int       idle_cycles = 0;
	int       stall_left = 0;
	bit       pix_gaps = 1'b0;
	bit       wr_stalls = 1'b0;

	always #4 clk = ~clk;

	// size as the unit uses it: 0 reads as 1, above MaxDim reads as MaxDim
	function automatic int unsigned eff_dim(input logic [DimW-1:0] v);
		if (v == '0)
			return 1;
		if (v > DimW'(MaxDim))
			return MaxDim;
		return int'(v);
	endfunction

	// ceil(dst/src), saturated at MaxRepeat
	function automatic int unsigned repeat_count(input int unsigned d, input int unsigned s);
		int unsigned r;
		r = (d + s - 1) / s;
		return (r > MaxRepeat) ? MaxRepeat : r;
	endfunction

	// expand one source pixel into its clipped block of writes, then advance
	function automatic void expand_pixel(input logic [PixW-1:0] p);
		int unsigned sw, sh, dw, dh, bx, by, rx, ry;
		bit          at_end;
		wr_word_t    blk [$];
		wr_word_t    w;
		sw = eff_dim(size_reg[REG_SRC_WIDTH]);
		sh = eff_dim(size_reg[REG_SRC_HEIGHT]);
		dw = eff_dim(size_reg[REG_DST_WIDTH]);
		dh = eff_dim(size_reg[REG_DST_HEIGHT]);
		bx = (dw * cur_col) / sw;
		by = (dh * cur_row) / sh;
		rx = repeat_count(dw, sw);
		ry = repeat_count(dh, sh);
		at_end = (cur_col == sw - 1) && (cur_row == sh - 1);
		for (int unsigned oy = 0; oy < ry && by + oy < dh; oy++) begin
			for (int unsigned ox = 0; ox < rx && bx + ox < dw; ox++) begin
				w.col       = CoordW'(bx + ox);
				w.row       = CoordW'(by + oy);
				w.pix       = p;
				w.run_end   = 1'b0;
				w.frame_end = at_end;
				blk = {blk, w};
			end
		end
		if (blk.size() != 0)
			blk[blk.size() - 1].run_end = 1'b1;
		foreach (blk[i])
			pending_writes = {pending_writes, blk[i]};
		if (cur_col + 1 >= sw) begin
			cur_col = 0;
			cur_row = (cur_row + 1 >= sh) ? 0 : cur_row + 1;
		end else begin
			cur_col = cur_col + 1;
		end
	endfunction

	// mostly small sizes, now and then zero, all ones or anything
	function automatic logic [DimW-1:0] pick_dim(input int unsigned top);
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return DimW'($urandom_range(0, 8191));
			default: return DimW'($urandom_range(1, top));
		endcase
	endfunction

	// send one pixel word, with an optional gap before it
	task automatic send_pixel(input logic [PixW-1:0] p);
		if (pix_gaps && $urandom_range(0, 4) == 0) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		pix.valid    <= 1'b1;
		pix.pixel_in <= p;
		do
			@(posedge clk);
		while (!pix.ready);
		expand_pixel(p);
	endtask

	// drop valid and let every pending write come out
	task automatic wait_drained();
		pix.valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register write; caller lowers cfg_we after the last one
	task automatic set_reg(input psc_reg_t idx, input logic [DimW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		size_reg[idx] = val;
		cur_col = 0;
		cur_row = 0;
	endtask

	task automatic set_dims(input logic [DimW-1:0] sw, input logic [DimW-1:0] sh,
			input logic [DimW-1:0] dw, input logic [DimW-1:0] dh);
		wait_drained();
		set_reg(REG_SRC_WIDTH, sw);
		set_reg(REG_SRC_HEIGHT, sh);
		set_reg(REG_DST_WIDTH, dw);
		set_reg(REG_DST_HEIGHT, dh);
		cfg_we <= 1'b0;
	endtask

	// sizes straight out of reset: every word is one write at the origin
	task automatic test_unit_sizes();
		send_pixel('0);
		send_pixel('1);
		send_pixel(32'hA5A5_5A5A);
		send_pixel(32'h5A5A_A5A5);
	endtask

	// 2x2 to 4x4: a full frame and one word into the next
	task automatic test_double_scale();
		set_dims(2, 2, 4, 4);
		for (int i = 0; i < 5; i++)
			send_pixel($urandom());
	endtask

	// zero and oversize registers, saturated repeats, 8x8 blocks, heavy downscale
	task automatic test_size_extremes();
		set_dims('0, '1, '1, DimW'(MaxDim));
		for (int i = 0; i < 3; i++)
			send_pixel($urandom());
		set_dims(1, 1, DimW'(MaxDim), DimW'(MaxDim));
		send_pixel($urandom());
		send_pixel($urandom());
		set_dims(DimW'(MaxDim), DimW'(MaxDim), 1, 1);
		send_pixel($urandom());
		send_pixel($urandom());
	endtask

	// a register write in mid-frame puts the position back at the origin
	task automatic test_frame_restart();
		set_dims(3, 2, 7, 5);
		send_pixel($urandom());
		send_pixel($urandom());
		wait_drained();
		set_reg(REG_DST_HEIGHT, 5);
		cfg_we <= 1'b0;
		send_pixel($urandom());
		send_pixel($urandom());
	endtask

	// random sizes per phase, random pixels, random idling; last phase at full rate
	task automatic test_random_frames();
		int pause_at;
		for (int ph = 0; ph < RandPhases; ph++) begin
			pix_gaps  = (ph < RandPhases - 1) && ($urandom_range(0, 3) != 0);
			wr_stalls = (ph < RandPhases - 1) && ($urandom_range(0, 3) != 0);
			set_dims(pick_dim(6), pick_dim(6), pick_dim(24), pick_dim(24));
			pause_at = $urandom_range(1, PhaseWords - 1);
			for (int i = 0; i < PhaseWords; i++) begin
				if (i == pause_at && (ph == 0 || $urandom_range(0, 1) == 0)) begin
					wait_drained();
					if ($urandom_range(0, 1) == 0) begin
						set_reg(psc_reg_t'($urandom_range(0, 3)), pick_dim(12));
						cfg_we <= 1'b0;
					end
				end
				send_pixel($urandom());
			end
		end
		pix_gaps  = 1'b0;
		wr_stalls = 1'b0;
	endtask

	// receiver: ready stalls in bursts while enabled
	always @(posedge clk) begin
		if (wr_stalls && stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 15);
		if (stall_left != 0) begin
			wr.ready <= 1'b0;
			stall_left--;
		end else begin
			wr.ready <= 1'b1;
		end
	end

	// compare each taken write with the oldest pending one
	always @(posedge clk) begin
		wr_word_t got, want;
		if (arst_n && wr.valid && wr.ready) begin
			got = '{wr.dest_col, wr.dest_row, wr.pixel_out, wr.last_of_run,
				wr.last_of_frame};
			if (pending_writes.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected write: col %0d row %0d pix %08h run %0b frame %0b",
						got.col, got.row, got.pix, got.run_end, got.frame_end);
			end else begin
				want = pending_writes.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: exp %0d/%0d %08h %0b%0b got %0d/%0d %08h %0b%0b",
							want.col, want.row, want.pix, want.run_end, want.frame_end,
							got.col, got.row, got.pix, got.run_end, got.frame_end);
				end
			end
		end
	end

	// watchdog: too long without any word moving
	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (wr.valid && wr.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		pix.valid    = 1'b0;
		pix.pixel_in = '0;
		wr.ready     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unit_sizes();
		test_double_scale();
		test_size_extremes();
		test_frame_restart();
		test_random_frames();

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_writes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
